### sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types and constants of the piecewise table transform
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned Depth    = 256;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned CountW   = AddrW + 1;
  localparam int unsigned FracBits = 16;

  typedef enum logic [1:0] {
    OP_APPLY  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_ORDER   = 3'd4
  } status_e;

  typedef enum logic {
    REG_INTERP = 1'b0,
    REG_OOR    = 1'b1
  } reg_idx_e;

  // one queued transaction between front and back
  typedef struct packed {
    op_e         op;
    logic        is_invalid;
    logic [31:0] key;
    logic [31:0] entry_value;
    logic        last;
  } item_t;

endpackage

### sv/ptt_front.sv
// ----------------------------------------------------------------------------
// ptt_front
// input stage and two-entry queue ahead of the execution engine
// ----------------------------------------------------------------------------
module ptt_front import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  item_t       in_item_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output item_t       q_item_o
);

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign in_stall  = (cnt_q == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

### sv/ptt_back.sv
// ----------------------------------------------------------------------------
// ptt_back
// sequencer: table search, interpolation, append with serial slope divide
// ----------------------------------------------------------------------------
module ptt_back import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  input  logic        interp_i,
  input  logic [31:0] oor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_value_o,
  output logic [2:0]  out_status_o,
  output logic        out_last_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RD0    = 11'b00000000010,
    S_CHK0   = 11'b00000000100,
    S_RDL    = 11'b00000001000,
    S_CHKL   = 11'b00000010000,
    S_SRCH   = 11'b00000100000,
    S_CMP    = 11'b00001000000,
    S_MUL    = 11'b00010000000,
    S_ADD    = 11'b00100000000,
    S_DIV    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  localparam int unsigned DivW = 32 + FracBits + 1;

  logic [31:0] bnd_mem [Depth];
  logic [31:0] val_mem [Depth];
  logic [31:0] slp_mem [Depth];

  state_e           st_q;
  logic [CountW-1:0] cnt_q;
  logic [31:0]      inv_q;
  item_t            it_q;
  logic [AddrW-1:0] ra_q;
  logic [AddrW-1:0] lo_q, hi_q;
  logic [31:0]      bnd_rd_q, val_rd_q, slp_rd_q;
  logic [31:0]      res_q;
  logic [2:0]       sts_q;
  logic             ovalid_q;
  logic signed [63:0] prod_q;
  // divider
  logic [DivW-1:0]  num_q, rem_q;
  logic [32:0]      den_q;
  logic [6:0]       dcnt_q;
  logic             neg_q;
  logic [31:0]      dv_val_q;

  logic signed [32:0] key_s, bnd_s;
  logic [AddrW-1:0]   mid;
  logic [DivW-1:0]    rem_sh;
  logic               wr_en;
  logic [31:0]        wr_slope;
  logic [DivW-1:0]    qmag;
  logic signed [DivW:0] qs;

  assign key_s = {it_q.key[31], it_q.key};
  assign bnd_s = {bnd_rd_q[31], bnd_rd_q};
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);
  assign rem_sh = {rem_q[DivW-2:0], num_q[DivW-1]};

  assign qmag = num_q;
  assign qs   = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  always_comb begin
    if (qs > $signed({{(DivW-31){1'b0}}, 31'h7fffffff})) wr_slope = 32'h7fffffff;
    else if (qs < -$signed({{(DivW-31){1'b0}}, 31'h7fffffff}) - 1) wr_slope = 32'h80000000;
    else wr_slope = qs[31:0];
  end

  assign q_pop_o      = (st_q == S_IDLE) && q_valid_i && !ovalid_q;
  assign out_valid_o  = ovalid_q;
  assign out_value_o  = res_q;
  assign out_status_o = sts_q;
  assign out_last_o   = it_q.last;

  assign wr_en = (st_q == S_DIV) && (dcnt_q == 7'd0);

  // memories
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bnd_mem[cnt_q[AddrW-1:0]] <= it_q.key;
      val_mem[cnt_q[AddrW-1:0]] <= it_q.entry_value;
      slp_mem[cnt_q[AddrW-1:0]] <= wr_slope;
    end
    bnd_rd_q <= bnd_mem[ra_q];
    val_rd_q <= val_mem[ra_q];
    slp_rd_q <= slp_mem[ra_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cnt_q    <= '0;
      inv_q    <= '0;
      ovalid_q <= 1'b0;
      ra_q     <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      dcnt_q   <= '0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (q_pop_o) begin
            it_q <= q_item_i;
            st_q <= S_RD0;
            // last entry address for append, first entry otherwise
            ra_q <= (q_item_i.op == OP_APPEND) ? (cnt_q[AddrW-1:0] - 1'b1) : '0;
          end
        end
        S_RD0: begin
          st_q <= S_CHK0;
        end
        S_CHK0: begin
          res_q <= '0;
          sts_q <= ST_OK;
          st_q  <= S_OUT;
          case (it_q.op)
            OP_APPLY: begin
              if (it_q.is_invalid) begin
                res_q <= inv_q;
                sts_q <= ST_INVALID;
              end else if (cnt_q == '0 || key_s < bnd_s) begin
                res_q <= oor_i;
                sts_q <= ST_RANGE;
              end else begin
                ra_q <= cnt_q[AddrW-1:0] - 1'b1;
                st_q <= S_RDL;
              end
            end
            OP_APPEND: begin
              if (it_q.is_invalid) begin
                inv_q <= it_q.entry_value;
              end else if (cnt_q[CountW-1]) begin
                sts_q <= ST_FULL;
              end else if (cnt_q != '0 && key_s < bnd_s) begin
                sts_q <= ST_ORDER;
              end else begin
                // set up sign-magnitude serial divide
                logic signed [32:0] dv, db;
                logic [32:0] adv;
                dv = {it_q.entry_value[31], it_q.entry_value} - {val_rd_q[31], val_rd_q};
                db = key_s - bnd_s;
                adv = dv[32] ? -dv : dv;
                neg_q  <= dv[32] ^ db[32];
                den_q  <= db[32] ? -db : db;
                rem_q  <= '0;
                if (cnt_q == '0 || db == '0) begin
                  num_q  <= '0;
                  dcnt_q <= 7'd0;
                end else begin
                  num_q  <= {adv, {FracBits{1'b0}}};
                  dcnt_q <= 7'(DivW);
                end
                st_q <= S_DIV;
              end
            end
            OP_CLEAR: cnt_q <= '0;
            default: ;
          endcase
        end
        S_RDL: st_q <= S_CHKL;
        S_CHKL: begin
          if (key_s >= bnd_s) begin
            res_q <= val_rd_q;
            st_q  <= S_OUT;
          end else begin
            lo_q <= '0;
            hi_q <= cnt_q[AddrW-1:0] - 1'b1;
            st_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hi_q - lo_q > 1) begin
            ra_q <= mid;
            st_q <= S_CMP;
          end else begin
            ra_q <= lo_q;
            st_q <= S_MUL;
          end
        end
        S_CMP: begin
          // data for ra_q comes via the registered read: wait with dcnt_q at 0, compare at 1
          if (dcnt_q == 7'd0) begin
            dcnt_q <= 7'd1;
          end else begin
            dcnt_q <= 7'd0;
            if (key_s > bnd_s) lo_q <= ra_q; else hi_q <= ra_q;
            st_q <= S_SRCH;
          end
        end
        S_MUL: begin
          // read lo: bound and value; then read slope at lo+1
          if (dcnt_q == 7'd0) begin
            dcnt_q <= 7'd1;
          end else if (dcnt_q == 7'd1) begin
            res_q  <= val_rd_q;
            dv_val_q <= bnd_rd_q;
            ra_q   <= lo_q + 1'b1;
            dcnt_q <= 7'd2;
          end else if (dcnt_q == 7'd2) begin
            dcnt_q <= 7'd3;
          end else begin
            dcnt_q <= 7'd0;
            prod_q <= 64'($signed(slp_rd_q)
                      * ($signed({it_q.key[31], it_q.key}) - $signed({dv_val_q[31], dv_val_q})));
            if (interp_i) st_q <= S_ADD;
            else st_q <= S_OUT;
          end
        end
        S_ADD: begin
          logic signed [64:0] s;
          s = {{33{res_q[31]}}, res_q} + {{17{prod_q[63]}}, prod_q[63:FracBits]};
          if (s > 65'sh7fffffff) res_q <= 32'h7fffffff;
          else if (s < -65'sh80000000) res_q <= 32'h80000000;
          else res_q <= s[31:0];
          st_q <= S_OUT;
        end
        S_DIV: begin
          if (dcnt_q == 7'd0) begin
            cnt_q <= cnt_q + 1'b1;
            st_q  <= S_OUT;
          end else begin
            if (rem_sh >= {{(DivW-33){1'b0}}, den_q}) begin
              rem_q <= rem_sh - {{(DivW-33){1'b0}}, den_q};
              num_q <= {num_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              num_q <= {num_q[DivW-2:0], 1'b0};
            end
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        S_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            st_q     <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/piecewise_table_transform_core.sv
// ----------------------------------------------------------------------------
// piecewise_table_transform_core
// breakpoint table with binary search and linear interpolation
// ----------------------------------------------------------------------------
// apply: binary search below the last bound, then table reads, a multiply and,
//   if interpolation is on, an add, over the single registered table read port
// append: one-bit-per-cycle slope divider, skipped when there is no slope
// clear, rejected and out-of-range items go straight to the result; one item in
//   the engine at a time, the next starts once the result transaction is taken
// reset: table empty, interpolation off, out-of-range value 0x80000000
module piecewise_table_transform_core import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode_i,
  input  logic        is_invalid_i,
  input  logic [31:0] key_i,
  input  logic [31:0] entry_value_i,
  input  logic        batch_last_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value_o,
  output logic [2:0]  status_o,
  output logic        result_last_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  item_t       in_item, q_item;
  logic        q_valid, q_pop;
  logic        interp_q;
  logic [31:0] oor_q;

  assign in_item = '{op: op_e'(opcode_i), is_invalid: is_invalid_i, key: key_i,
                     entry_value: entry_value_i, last: batch_last_i};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 1'b0;
      oor_q    <= 32'h80000000;
    end else if (cfg_valid) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_INTERP: interp_q <= cfg_data_i[0];
        REG_OOR:    oor_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptt_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  ptt_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .interp_i(interp_q), .oor_i(oor_q), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .out_value_o(result_value_o),
    .out_status_o(status_o), .out_last_o(result_last_o)
  );

endmodule

### tb/piecewise_table_transform_checker.sv
// ----------------------------------------------------------------------------
// piecewise_table_transform_checker
// monitors the request, result and register channels of the table transform,
// keeps its own copy of the breakpoint table and compares every result in order
// ----------------------------------------------------------------------------
module piecewise_table_transform_checker import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode_i,
  input  logic        is_invalid_i,
  input  logic [31:0] key_i,
  input  logic [31:0] entry_value_i,
  input  logic        batch_last_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] result_value_i,
  input  logic [2:0]  status_i,
  input  logic        result_last_i,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          results_seen_o
);

  typedef struct {
    logic [31:0] value;
    status_e     status;
    logic        last;
  } outcome_t;

  logic signed [31:0] bound_tab [Depth];
  logic signed [31:0] value_tab [Depth];
  logic signed [31:0] slope_tab [Depth];
  int unsigned        entries;
  logic [31:0]        invalid_value;
  logic               interp_on;
  logic [31:0]        oor_value;
  outcome_t           expected_q [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // updates the table copy and returns the outcome of one transaction
  function automatic outcome_t transform(op_e op, logic inv, logic signed [31:0] key,
                                         logic signed [31:0] val, logic last);
    outcome_t o;
    int unsigned lo, hi, mid, top;
    longint slope, dv, prod;
    o.value  = '0;
    o.status = ST_OK;
    o.last   = last;
    case (op)
      OP_APPLY: begin
        if (inv) begin
          o.value  = invalid_value;
          o.status = ST_INVALID;
        end else if (entries == 0 || key < bound_tab[0]) begin
          o.value  = oor_value;
          o.status = ST_RANGE;
        end else begin
          top = entries - 1;
          if (key >= bound_tab[top]) begin
            o.value = value_tab[top];
          end else begin
            lo = 0;
            hi = top;
            while (hi - lo > 1) begin
              mid = lo + (hi - lo) / 2;
              if (key > bound_tab[mid]) lo = mid;
              else hi = mid;
            end
            if (!interp_on) begin
              o.value = value_tab[lo];
            end else begin
              // slope toward the next entry lives at lo+1
              prod = longint'(slope_tab[lo + 1]) * (longint'(key) - longint'(bound_tab[lo]));
              o.value = 32'(clamp32(longint'(value_tab[lo]) + (prod >>> FracBits)));
            end
          end
        end
      end
      OP_APPEND: begin
        if (inv) begin
          invalid_value = val;
        end else if (entries >= Depth) begin
          o.status = ST_FULL;
        end else if (entries > 0 && key < bound_tab[entries - 1]) begin
          o.status = ST_ORDER;
        end else begin
          slope = 0;
          if (entries > 0 && key != bound_tab[entries - 1]) begin
            dv = longint'(val) - longint'(value_tab[entries - 1]);
            slope = clamp32((dv * 64'sd65536) /
                            (longint'(key) - longint'(bound_tab[entries - 1])));
          end
          bound_tab[entries] = key;
          value_tab[entries] = val;
          slope_tab[entries] = 32'(slope);
          entries++;
        end
      end
      OP_CLEAR: entries = 0;
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      entries       = 0;
      invalid_value = '0;
      interp_on     = 1'b0;
      oor_value     = 32'h8000_0000;
      expected_q.delete();
      mismatches_o   = 0;
      pending_o      = 0;
      results_seen_o = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen_o++;
        if (expected_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("unexpected result value=%h status=%0d", result_value_i, status_i);
        end else begin
          exp_o = expected_q.pop_front();
          if (result_value_i !== exp_o.value || status_i !== exp_o.status ||
              result_last_i !== exp_o.last) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("mismatch: value %h/%h status %0d/%0d last %0b/%0b (exp/act)",
                       exp_o.value, result_value_i, exp_o.status, status_i,
                       exp_o.last, result_last_i);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(transform(op_e'(opcode_i), is_invalid_i, key_i,
                                       entry_value_i, batch_last_i));
      if (cfg_valid && cfg_ready) begin
        if (reg_idx_e'(cfg_index_i) == REG_INTERP) interp_on = cfg_data_i[0];
        else oor_value = cfg_data_i;
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### tb/piecewise_table_transform_core_test.sv
// ----------------------------------------------------------------------------
// piecewise_table_transform_core_test
// drives table loads, clears and samples with random gaps and back pressure
// through several register settings; the checker judges every result
// ----------------------------------------------------------------------------
module piecewise_table_transform_core_test import ptt_pkg::*;;

  logic        clk_i, rst_ni;
  logic        in_valid, in_stall;
  logic [1:0]  opcode_i;
  logic        is_invalid_i, batch_last_i;
  logic [31:0] key_i, entry_value_i;
  logic        out_valid, out_stall;
  logic [31:0] result_value_o;
  logic [2:0]  status_o;
  logic        result_last_o;
  logic        cfg_valid, cfg_ready, cfg_index_i;
  logic [31:0] cfg_data_i;
  int          mismatches, pending, results_seen;
  int          sent, settings, cycles;
  bit          quiet;
  logic signed [31:0] tab_lo, tab_hi;

  localparam int CycleLimit = 1_500_000;

  piecewise_table_transform_core dut (.*);

  piecewise_table_transform_checker chk (
    .clk_i, .rst_ni, .in_valid, .in_stall, .opcode_i, .is_invalid_i, .key_i,
    .entry_value_i, .batch_last_i, .out_valid, .out_stall,
    .result_value_i(result_value_o), .status_i(status_o), .result_last_i(result_last_o),
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // result side: random stall per transaction, one long hold-off
  initial begin
    int n, taken;
    out_stall = 1'b1;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (taken == 120) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk_i);
      end else begin
        n = quiet ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
          out_stall = 1'b1;
          repeat (n - 1) @(negedge clk_i);
          @(negedge clk_i);
        end
      end
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  task automatic send(op_e op, logic inv, logic [31:0] key, logic [31:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i      = op;
    is_invalid_i  = inv;
    key_i         = key;
    entry_value_i = val;
    batch_last_i  = 1'($urandom_range(0, 1));
    in_valid      = 1'b1;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic finish_stream();
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // registers change only once every result is back and the engine is idle
  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    finish_stream();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid   = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // clear, then n ascending entries; step of zero gives equal bounds
  task automatic load_table(int n);
    logic signed [31:0] k;
    send(OP_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom);
    k = -$signed(32'($urandom_range(0, 32'h4000_0000)));
    tab_lo = k;
    for (int i = 0; i < n; i++) begin
      send(OP_APPEND, 1'b0, k, $urandom);
      tab_hi = k;
      k = k + ($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 32'h10_0000));
    end
  endtask

  task automatic sample_table();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) send(OP_APPLY, 1'b0, $urandom, $urandom);
    else if (r == 1) send(OP_APPLY, 1'b0, tab_lo - $urandom_range(0, 3), $urandom);
    else if (r == 2) send(OP_APPLY, 1'b0, tab_hi + $urandom_range(0, 3), $urandom);
    else send(OP_APPLY, 1'b0, tab_lo + $urandom_range(0, tab_hi - tab_lo), $urandom);
  endtask

  task automatic random_phase(int count);
    int r, target;
    target = sent + count;
    while (sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        load_table($urandom_range(1, 14));
        repeat ($urandom_range(2, 10)) sample_table();
      end else if (r == 7) begin
        send(op_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom, $urandom);
      end else if (r == 8) begin
        send(OP_APPEND, 1'b0, tab_hi - $urandom_range(1, 1000), $urandom);
      end else begin
        send($urandom_range(0, 1) ? OP_APPLY : OP_APPEND, 1'b1, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    opcode_i = OP_NONE;
    is_invalid_i = 1'b0;
    key_i = '0;
    entry_value_i = '0;
    batch_last_i = 1'b0;
    cfg_valid = 1'b0;
    cfg_index_i = REG_INTERP;
    cfg_data_i = '0;
    sent = 0;
    settings = 1;
    quiet = 1'b0;
    tab_lo = '0;
    tab_hi = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, invalid handling, extreme bounds and values
    send(OP_APPLY, 1'b0, 32'h8000_0000, '0);
    send(OP_APPLY, 1'b1, '0, '0);
    send(OP_APPEND, 1'b1, '0, 32'h7fff_ffff);
    send(OP_APPLY, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_APPEND, 1'b0, 32'h8000_0000, 32'h8000_0000);
    send(OP_APPEND, 1'b0, 32'h8000_0000, 32'h7fff_ffff);
    send(OP_APPEND, 1'b0, '0, 32'h7fff_ffff);
    send(OP_APPEND, 1'b0, 32'h0000_0002, 32'h8000_0000);
    send(OP_APPEND, 1'b0, 32'h0000_0001, '0);
    send(OP_APPEND, 1'b0, 32'h7fff_ffff, 32'h1234_5678);
    send(OP_APPLY, 1'b0, 32'h8000_0000, '0);
    send(OP_APPLY, 1'b0, 32'h0000_0001, '0);
    send(OP_APPLY, 1'b0, 32'h4000_0000, '0);
    send(OP_APPLY, 1'b0, 32'h7fff_ffff, '0);
    send(OP_NONE, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_CLEAR, 1'b0, '0, '0);
    send(OP_APPLY, 1'b0, 32'h7fff_ffff, '0);
    write_reg(REG_INTERP, 32'h1);
    write_reg(REG_OOR, 32'h7fff_ffff);
    settings++;
    send(OP_APPEND, 1'b0, '0, 32'h8000_0000);
    send(OP_APPEND, 1'b0, 32'h0000_0002, 32'h7fff_ffff);
    send(OP_APPEND, 1'b0, 32'h0001_0000, 32'h8000_0000);
    send(OP_APPLY, 1'b0, 32'h0000_0001, '0);
    send(OP_APPLY, 1'b0, 32'h0000_8000, '0);
    send(OP_APPLY, 1'b0, 32'hffff_ffff, '0);

    // random: interpolation on with a full table at its end, then off in two settings, then on again
    random_phase(20);
    quiet = 1'b1;
    load_table(Depth);
    send(OP_APPEND, 1'b0, 32'h7fff_ffff, $urandom);
    send(OP_APPEND, 1'b1, $urandom, $urandom);
    repeat (20) sample_table();
    quiet = 1'b0;
    write_reg(REG_INTERP, 32'h0);
    write_reg(REG_OOR, $urandom);
    settings++;
    random_phase(20);
    write_reg(REG_INTERP, 32'hffff_fffe);
    write_reg(REG_OOR, 32'h8000_0000);
    settings++;
    random_phase(20);
    write_reg(REG_INTERP, 32'h1);
    write_reg(REG_OOR, $urandom);
    settings++;
    random_phase(20);
    finish_stream();

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d transactions, checked %0d results over %0d register settings",
             sent, results_seen, settings);
    $display("including a full table, rejected loads and a long result hold-off");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
